// ----- sv/i2cee_pkg.sv -----
// Shared types and constants of the I2C EEPROM transfer engine.
// No dependencies; the top level, i2cee_cfg and i2cee_seq refer to this package.
package i2cee_pkg;

  // Default depth of the write data buffer
  localparam int BUFFER_DEPTH_DEF = 256;

  // Configuration register resets
  localparam logic [6:0] DEV_ADDR_RST = 7'd80;
  localparam logic [7:0] MAX_ATT_RST  = 8'd32;

  // Configuration register indexes (byte address bit 2)
  localparam logic REG_DEV_ADDR = 1'b0;
  localparam logic REG_MAX_ATT  = 1'b1;

  // Input word action codes
  localparam logic [2:0] ACT_LOAD       = 3'd0;
  localparam logic [2:0] ACT_START_WR   = 3'd1;
  localparam logic [2:0] ACT_START_RD   = 3'd2;
  localparam logic [2:0] ACT_BUS_DONE   = 3'd3;
  localparam logic [2:0] ACT_WAIT_OVER  = 3'd4;

  // Bus unit status codes
  localparam logic [7:0] ST_START_MASK = 8'h18;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_SEND      = 3'd2,
    CMD_RECV_ACK  = 3'd3,
    CMD_RECV_NACK = 3'd4,
    CMD_STOP      = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_W = 4'd1,
    PH_SLA_W   = 4'd2,
    PH_ADDR_H  = 4'd3,
    PH_ADDR_L  = 4'd4,
    PH_DATA_W  = 4'd5,
    PH_START_R = 4'd6,
    PH_SLA_R   = 4'd7,
    PH_RECV    = 4'd8,
    PH_WAIT    = 4'd9
  } phase_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] addr_high;
    logic [7:0] addr_low;
    logic [7:0] length;
    logic [7:0] buffer_index;
    logic [7:0] byte_value;
    logic [7:0] bus_status;
  } in_item_t;

  typedef struct packed {
    cmd_t       bus_command;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [7:0] read_position;
    logic       wait_request;
    logic       finished;
    logic       failed;
  } out_item_t;

  // Live configuration handed from the register block to the sequencer
  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] max_attempts;
  } cfg_t;

endpackage

// ----- sv/i2cee_in_if.sv -----
// Input channel of the I2C EEPROM transfer engine: valid/ready plus one request word.
// Depends on nothing else.
interface i2cee_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] addr_high;
  logic [7:0] addr_low;
  logic [7:0] length;
  logic [7:0] buffer_index;
  logic [7:0] byte_value;
  logic [7:0] bus_status;

  modport source (
    output valid, action, addr_high, addr_low, length, buffer_index, byte_value, bus_status,
    input  ready
  );
  modport sink (
    input  valid, action, addr_high, addr_low, length, buffer_index, byte_value, bus_status,
    output ready
  );
endinterface

// ----- sv/i2cee_out_if.sv -----
// Result channel of the I2C EEPROM transfer engine: valid/ready plus one result word.
// Depends on nothing else.
interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_command;
  logic [7:0] send_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [7:0] read_position;
  logic       wait_request;
  logic       finished;
  logic       failed;

  modport source (
    output valid, bus_command, send_byte, read_valid, read_byte, read_position,
           wait_request, finished, failed,
    input  ready
  );
  modport sink (
    input  valid, bus_command, send_byte, read_valid, read_byte, read_position,
           wait_request, finished, failed,
    output ready
  );
endinterface

// ----- sv/i2c_eeprom_transfer_engine.sv -----
// Top level of the I2C EEPROM transfer engine: input and result registers, buffer, config registers, sequencer.
// Depends on i2cee_pkg, i2cee_in_if, i2cee_out_if, i2cee_ram, i2cee_cfg and i2cee_seq.
//
// Sequencer for EEPROM random-address writes and reads over a byte-level I2C bus
// unit. Write bytes are loaded into the buffer first (a load takes effect when its
// word is accepted); a start request then yields one bus command per result word,
// and each bus-done word is answered by the next command, a received byte, a STOP
// with retry wait, or the final STOP. One word is accepted every clock cycle while
// the result side keeps up. A word waits in the input register until it is consumed;
// its result then goes into the result register, from which the result side takes it.
// Send data is read from the buffer RAM ahead of use through its read register, using
// the position that the previous word leaves. Configuration: byte address 0 holds
// the 7-bit device address, address 4 the attempt limit; write them only while no
// transfer is in progress.
module i2c_eeprom_transfer_engine #(
  parameter int BUFFER_DEPTH = i2cee_pkg::BUFFER_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  i2cee_in_if.sink     in_ch,
  i2cee_out_if.source  out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  i2cee_pkg::cfg_t      cfg;
  i2cee_pkg::in_item_t  in_word;
  i2cee_pkg::in_item_t  in_item_r;
  logic                 in_v_r;
  i2cee_pkg::out_item_t out_item_r;
  logic                 out_v_r;
  i2cee_pkg::out_item_t res;
  logic                 res_has;
  logic                 proc;
  logic                 in_acc;
  logic                 buf_we;
  logic [AW-1:0]        rd_addr;
  logic [7:0]           rd_data;

  assign in_word.action       = in_ch.action;
  assign in_word.addr_high    = in_ch.addr_high;
  assign in_word.addr_low     = in_ch.addr_low;
  assign in_word.length       = in_ch.length;
  assign in_word.buffer_index = in_ch.buffer_index;
  assign in_word.byte_value   = in_ch.byte_value;
  assign in_word.bus_status   = in_ch.bus_status;

  // Handshake: the input word moves on when the result register is free or drains
  assign proc         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || proc;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc && res_has) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_has) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.bus_command   = out_item_r.bus_command;
  assign out_ch.send_byte     = out_item_r.send_byte;
  assign out_ch.read_valid    = out_item_r.read_valid;
  assign out_ch.read_byte     = out_item_r.read_byte;
  assign out_ch.read_position = out_item_r.read_position;
  assign out_ch.wait_request  = out_item_r.wait_request;
  assign out_ch.finished      = out_item_r.finished;
  assign out_ch.failed        = out_item_r.failed;

  // Buffer loads write on acceptance; indexes past the buffer are dropped
  assign buf_we = in_acc && (in_word.action == i2cee_pkg::ACT_LOAD) &&
                  ({1'b0, in_word.buffer_index} < 9'(BUFFER_DEPTH));

  i2cee_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (in_word.buffer_index[AW-1:0]),
    .wdata (in_word.byte_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  i2cee_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  i2cee_seq #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc    (proc),
    .item    (in_item_r),
    .cfg     (cfg),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .res_has (res_has),
    .res     (res)
  );

endmodule

// ----- sv/i2cee_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cee_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/i2cee_cfg.sv -----
// APB-style configuration registers: device address and attempt limit.
// Depends on i2cee_pkg.
module i2cee_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output i2cee_pkg::cfg_t    cfg
);

  logic [6:0] dev_r;
  logic [7:0] max_r;
  logic       wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; low address bits are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= i2cee_pkg::DEV_ADDR_RST;
      max_r <= i2cee_pkg::MAX_ATT_RST;
    end else if (wr_en) begin
      if (paddr[2] == i2cee_pkg::REG_DEV_ADDR) begin
        dev_r <= pwdata[6:0];
      end else begin
        max_r <= pwdata[7:0];
      end
    end
  end

  // Read mux
  always_comb begin
    if (paddr[2] == i2cee_pkg::REG_MAX_ATT) begin
      prdata = {24'd0, max_r};
    end else begin
      prdata = {25'd0, dev_r};
    end
  end

  assign cfg.device_address = dev_r;
  assign cfg.max_attempts   = max_r;

endmodule

// ----- sv/i2cee_seq.sv -----
// Transaction sequencer: phase state, retry counting and result word generation.
// Depends on i2cee_pkg; buffer data for rd_addr arrives through the read register of i2cee_ram.
module i2cee_seq #(
  parameter int  BUFFER_DEPTH = i2cee_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc,      // word in the input register is consumed
  input  i2cee_pkg::in_item_t  item,
  input  i2cee_pkg::cfg_t      cfg,
  input  logic [7:0]           rd_data,
  output logic [AW-1:0]        rd_addr,
  output logic                 res_has,
  output i2cee_pkg::out_item_t res
);

  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

  i2cee_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]        att_r, att_nxt;
  logic [7:0]        bp_r, bp_nxt;
  logic [7:0]        addr_h_r, addr_h_nxt;
  logic [7:0]        addr_l_r, addr_l_nxt;
  logic [7:0]        len_r, len_nxt;
  logic              rd_r, rd_nxt;
  logic [AW-1:0]     bufp_r, bufp_nxt;   // byte position modulo buffer depth

  logic [7:0]        att_inc;
  logic [7:0]        bp_inc;
  logic [AW-1:0]     bufp_inc;
  logic              start_ok;

  assign att_inc  = att_r + 8'd1;
  assign bp_inc   = bp_r + 8'd1;
  assign bufp_inc = (bufp_r == LAST_IDX) ? '0 : bufp_r + AW'(1);
  assign start_ok = ((item.bus_status & i2cee_pkg::ST_START_MASK) == i2cee_pkg::ST_START) ||
                    ((item.bus_status & i2cee_pkg::ST_START_MASK) == i2cee_pkg::ST_RESTART);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= i2cee_pkg::PH_IDLE;
      att_r    <= '0;
      bp_r     <= '0;
      addr_h_r <= '0;
      addr_l_r <= '0;
      len_r    <= '0;
      rd_r     <= 1'b0;
      bufp_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      att_r    <= att_nxt;
      bp_r     <= bp_nxt;
      addr_h_r <= addr_h_nxt;
      addr_l_r <= addr_l_nxt;
      len_r    <= len_nxt;
      rd_r     <= rd_nxt;
      bufp_r   <= bufp_nxt;
    end
  end

  // Next state and result word
  always_comb begin
    phase_nxt  = phase_r;
    att_nxt    = att_r;
    bp_nxt     = bp_r;
    addr_h_nxt = addr_h_r;
    addr_l_nxt = addr_l_r;
    len_nxt    = len_r;
    rd_nxt     = rd_r;
    bufp_nxt   = bufp_r;
    res_has    = 1'b0;
    res        = '0;
    res.bus_command = i2cee_pkg::CMD_NONE;

    if (proc) begin
      case (item.action)
        i2cee_pkg::ACT_START_WR, i2cee_pkg::ACT_START_RD: begin
          if (phase_r == i2cee_pkg::PH_IDLE) begin
            addr_h_nxt = item.addr_high;
            addr_l_nxt = item.addr_low;
            len_nxt    = item.length;
            rd_nxt     = (item.action == i2cee_pkg::ACT_START_RD);
            att_nxt    = '0;
            bp_nxt     = '0;
            bufp_nxt   = '0;
            res_has    = 1'b1;
            res.bus_command = i2cee_pkg::CMD_START;
            phase_nxt  = i2cee_pkg::PH_START_W;
          end
        end
        i2cee_pkg::ACT_WAIT_OVER: begin
          if (phase_r == i2cee_pkg::PH_WAIT) begin
            bp_nxt     = '0;
            bufp_nxt   = '0;
            res_has    = 1'b1;
            res.bus_command = i2cee_pkg::CMD_START;
            phase_nxt  = i2cee_pkg::PH_START_W;
          end
        end
        i2cee_pkg::ACT_BUS_DONE: begin
          if (phase_r != i2cee_pkg::PH_IDLE && phase_r != i2cee_pkg::PH_WAIT) begin
            res_has = 1'b1;
            // Status check of the step just completed
            if ((phase_r == i2cee_pkg::PH_START_W && !start_ok) ||
                (phase_r == i2cee_pkg::PH_START_R && !start_ok) ||
                (phase_r == i2cee_pkg::PH_SLA_W &&
                 item.bus_status != i2cee_pkg::ST_SLA_W_ACK) ||
                (phase_r == i2cee_pkg::PH_SLA_R &&
                 item.bus_status != i2cee_pkg::ST_SLA_R_ACK) ||
                ((phase_r == i2cee_pkg::PH_ADDR_H || phase_r == i2cee_pkg::PH_ADDR_L ||
                  phase_r == i2cee_pkg::PH_DATA_W) &&
                 item.bus_status != i2cee_pkg::ST_DATA_ACK)) begin
              // Failed step: stop, then retry or give up
              att_nxt = att_inc;
              res.bus_command = i2cee_pkg::CMD_STOP;
              if (att_inc >= cfg.max_attempts) begin
                res.finished = 1'b1;
                res.failed   = 1'b1;
                phase_nxt    = i2cee_pkg::PH_IDLE;
              end else begin
                res.wait_request = 1'b1;
                phase_nxt        = i2cee_pkg::PH_WAIT;
              end
            end else begin
              case (phase_r)
                i2cee_pkg::PH_START_W: begin
                  res.bus_command = i2cee_pkg::CMD_SEND;
                  res.send_byte   = {cfg.device_address, 1'b0};
                  phase_nxt       = i2cee_pkg::PH_SLA_W;
                end
                i2cee_pkg::PH_SLA_W: begin
                  res.bus_command = i2cee_pkg::CMD_SEND;
                  res.send_byte   = addr_h_r;
                  phase_nxt       = i2cee_pkg::PH_ADDR_H;
                end
                i2cee_pkg::PH_ADDR_H: begin
                  res.bus_command = i2cee_pkg::CMD_SEND;
                  res.send_byte   = addr_l_r;
                  phase_nxt       = i2cee_pkg::PH_ADDR_L;
                end
                i2cee_pkg::PH_ADDR_L: begin
                  if (rd_r) begin
                    res.bus_command = i2cee_pkg::CMD_START;
                    phase_nxt       = i2cee_pkg::PH_START_R;
                  end else if (len_r == 8'd0) begin
                    res.bus_command = i2cee_pkg::CMD_STOP;
                    res.finished    = 1'b1;
                    phase_nxt       = i2cee_pkg::PH_IDLE;
                  end else begin
                    // rd_data holds buffer entry 0
                    bp_nxt          = '0;
                    bufp_nxt        = '0;
                    res.bus_command = i2cee_pkg::CMD_SEND;
                    res.send_byte   = rd_data;
                    phase_nxt       = i2cee_pkg::PH_DATA_W;
                  end
                end
                i2cee_pkg::PH_DATA_W: begin
                  bp_nxt   = bp_inc;
                  bufp_nxt = bufp_inc;
                  if (bp_inc >= len_r) begin
                    res.bus_command = i2cee_pkg::CMD_STOP;
                    res.finished    = 1'b1;
                    phase_nxt       = i2cee_pkg::PH_IDLE;
                  end else begin
                    // rd_data holds the entry after the current position
                    res.bus_command = i2cee_pkg::CMD_SEND;
                    res.send_byte   = rd_data;
                  end
                end
                i2cee_pkg::PH_START_R: begin
                  res.bus_command = i2cee_pkg::CMD_SEND;
                  res.send_byte   = {cfg.device_address, 1'b1};
                  phase_nxt       = i2cee_pkg::PH_SLA_R;
                end
                i2cee_pkg::PH_SLA_R: begin
                  bp_nxt = '0;
                  if (len_r == 8'd0) begin
                    res.bus_command = i2cee_pkg::CMD_STOP;
                    res.finished    = 1'b1;
                    phase_nxt       = i2cee_pkg::PH_IDLE;
                  end else begin
                    res.bus_command = (len_r == 8'd1) ? i2cee_pkg::CMD_RECV_NACK
                                                      : i2cee_pkg::CMD_RECV_ACK;
                    phase_nxt       = i2cee_pkg::PH_RECV;
                  end
                end
                i2cee_pkg::PH_RECV: begin
                  bp_nxt            = bp_inc;
                  res.read_valid    = 1'b1;
                  res.read_byte     = item.byte_value;
                  res.read_position = bp_r;
                  if (bp_inc >= len_r) begin
                    res.bus_command = i2cee_pkg::CMD_STOP;
                    res.finished    = 1'b1;
                    phase_nxt       = i2cee_pkg::PH_IDLE;
                  end else begin
                    res.bus_command = (bp_inc == len_r - 8'd1) ? i2cee_pkg::CMD_RECV_NACK
                                                               : i2cee_pkg::CMD_RECV_ACK;
                  end
                end
                default: begin
                  res_has = 1'b0;
                end
              endcase
            end
          end
        end
        default: begin
          // Loads go straight to the buffer; unused codes do nothing
        end
      endcase
    end
  end

  // Buffer read address for the next word: the entry a data phase step will send
  always_comb begin
    if (phase_nxt == i2cee_pkg::PH_DATA_W) begin
      rd_addr = (bufp_nxt == LAST_IDX) ? '0 : bufp_nxt + AW'(1);
    end else begin
      rd_addr = '0;
    end
  end

endmodule
